// ===== hdl/cau_pkg.sv =====
// package: widths, operation codes and status codes for the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;
    localparam int DATA_W_DEF = 32;
    localparam int FRAC_W_DEF = 16;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [CMD_W-1:0] OP_ADD = 3'd0;
    localparam logic [CMD_W-1:0] OP_SUB = 3'd1;
    localparam logic [CMD_W-1:0] OP_MUL = 3'd2;
    localparam logic [CMD_W-1:0] OP_DIV = 3'd3;
    localparam logic [CMD_W-1:0] OP_CNJ = 3'd4;
    localparam logic [CMD_W-1:0] OP_MAG = 3'd5;
    localparam logic [CMD_W-1:0] OP_INV = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DBZ = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd2;
endpackage

// ===== hdl/cau_divstage.sv =====
// one restoring step of the pipelined quotient unit
`timescale 1ns / 1ps
module cau_divstage import cau_pkg::*; #(
    parameter int RW = 8
) (
    input  logic [RW-1:0] rem_in,
    input  logic          bit_in,
    input  logic [RW-1:0] div_in,
    output logic [RW-1:0] rem_out,
    output logic          q_out
);
    logic [RW:0] shifted;
    logic [RW:0] trial;

    // shift in next numerator bit and try a subtract
    always_comb
    begin
        shifted = {rem_in, bit_in};
        trial   = shifted - {1'b0, div_in};
        q_out   = !trial[RW];
        rem_out = q_out ? trial[RW-1:0] : shifted[RW-1:0];
    end
endmodule

// ===== hdl/complex_arith_unit.sv =====
// top level: pipelined complex arithmetic unit, signed fixed point
`timescale 1ns / 1ps
// Complex ALU on a stream. s_axis carries one operation per transfer: tuser
// holds the operation code, tdata the operands a_re, a_im, b_re, b_im. For
// each transfer exactly one result leaves on m_axis: tdata holds res_re and
// res_im, tuser the status (ok, divide by zero, saturated overflow).
// Results are rounded toward minus infinity and saturated.
// Between input transfer and result lie three operand, product and numerator
// stages, the restoring quotient and root pipeline at one bit a stage, NB =
// 2*DATA_WIDTH + 2*FRAC_BITS + 2 being the quotient length, and the output
// register. One item enters every cycle while the output is not stalled.
// All stages advance together on a single enable; when m_axis_tready is low
// with a result waiting, the whole pipe holds and s_axis_tready drops, so no
// item is lost or repeated. Reset empties the pipe (valid bits cleared);
// there is no other state.
module complex_arith_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int FRAC_BITS  = FRAC_W_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // a_re, a_im, b_re, b_im from bit 0 up
    input  logic [4*DATA_WIDTH-1:0] s_axis_tdata,
    // cmd
    input  logic [CMD_W-1:0]        s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // res_re, res_im from bit 0 up
    output logic [2*DATA_WIDTH-1:0] m_axis_tdata,
    // status
    output logic [STAT_W-1:0]       m_axis_tuser
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2*W + 2;            // product sums
    localparam int NW = PW + 2*FRAC_BITS;   // shifted numerator magnitude
    localparam int DW = 2*W + 1;            // divisor width
    localparam int RW = DW + 1;             // remainder width
    localparam int NB = NW;                 // quotient bits
    localparam int SB = W + 1;              // root bits
    localparam int SRW = W + 3;             // root remainder width
    localparam int XW = NW + 1;             // signed result width

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: operand register
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic [CMD_W-1:0] cmd1_reg;
    logic v1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ar1_reg  <= s_axis_tdata[W-1:0];
            ai1_reg  <= s_axis_tdata[2*W-1:W];
            br1_reg  <= s_axis_tdata[3*W-1:2*W];
            bi1_reg  <= s_axis_tdata[4*W-1:3*W];
            cmd1_reg <= s_axis_tuser;
        end
    end

    // stage 2: six products, operand selection by op
    logic signed [W-1:0] pa1, pb1, pc1, pd1, pe1, pf1, pg1, ph1;
    always_comb
    begin
        pa1 = ar1_reg; pb1 = br1_reg; pc1 = ai1_reg; pd1 = bi1_reg;
        pe1 = ar1_reg; pf1 = bi1_reg; pg1 = ai1_reg; ph1 = br1_reg;
        if (cmd1_reg == OP_DIV)
        begin
            pe1 = br1_reg; pf1 = br1_reg; pg1 = bi1_reg; ph1 = bi1_reg;
        end
        else if (cmd1_reg == OP_MAG || cmd1_reg == OP_INV)
        begin
            pe1 = ar1_reg; pf1 = ar1_reg; pg1 = ai1_reg; ph1 = ai1_reg;
        end
    end
    logic signed [2*W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [W-1:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic [CMD_W-1:0] cmd2_reg;
    logic v2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= pa1 * pb1;   // ar*br
            p1_reg <= pc1 * pd1;   // ai*bi
            p2_reg <= ar1_reg * bi1_reg;
            p3_reg <= ai1_reg * br1_reg;
            p4_reg <= pe1 * pf1;   // d terms
            p5_reg <= pg1 * ph1;
            ar2_reg <= ar1_reg; ai2_reg <= ai1_reg;
            br2_reg <= br1_reg; bi2_reg <= bi1_reg;
            cmd2_reg <= cmd1_reg;
        end
    end

    // stage 3: sums, numerators, direct results
    logic signed [PW-1:0] sr2, si2;
    logic [DW-1:0] d2;
    logic signed [XW-1:0] nr2, ni2, dr2, di2;
    logic direct2;
    always_comb
    begin
        d2  = DW'(p4_reg) + DW'(p5_reg);
        sr2 = '0; si2 = '0; nr2 = '0; ni2 = '0; dr2 = '0; di2 = '0;
        direct2 = 1'b1;
        case (cmd2_reg)
            OP_ADD:
            begin
                dr2 = XW'(ar2_reg) + XW'(br2_reg);
                di2 = XW'(ai2_reg) + XW'(bi2_reg);
            end
            OP_SUB:
            begin
                dr2 = XW'(ar2_reg) - XW'(br2_reg);
                di2 = XW'(ai2_reg) - XW'(bi2_reg);
            end
            OP_MUL:
            begin
                sr2 = PW'(p0_reg) - PW'(p1_reg);
                si2 = PW'(p2_reg) + PW'(p3_reg);
                dr2 = XW'(sr2 >>> FRAC_BITS);
                di2 = XW'(si2 >>> FRAC_BITS);
            end
            OP_CNJ:
            begin
                dr2 = XW'(ar2_reg);
                di2 = -XW'(ai2_reg);
            end
            OP_DIV:
            begin
                direct2 = 1'b0;
                sr2 = PW'(p0_reg) + PW'(p1_reg);
                si2 = PW'(p3_reg) - PW'(p2_reg);
                nr2 = XW'(sr2) <<< FRAC_BITS;
                ni2 = XW'(si2) <<< FRAC_BITS;
            end
            OP_INV:
            begin
                direct2 = 1'b0;
                nr2 = XW'(ar2_reg) <<< (2*FRAC_BITS);
                ni2 = (-XW'(ai2_reg)) <<< (2*FRAC_BITS);
            end
            OP_MAG:  direct2 = 1'b0;
            default: direct2 = 1'b1;
        endcase
    end
    logic [NW-1:0] mr3_reg, mi3_reg;
    logic sr3_reg, si3_reg;
    logic [DW-1:0] d3_reg;
    logic signed [XW-1:0] dr3_reg, di3_reg;
    logic [CMD_W-1:0] cmd3_reg;
    logic direct3_reg, v3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr3_reg <= nr2[XW-1];
            si3_reg <= ni2[XW-1];
            mr3_reg <= nr2[XW-1] ? NW'(-nr2) : NW'(nr2);
            mi3_reg <= ni2[XW-1] ? NW'(-ni2) : NW'(ni2);
            d3_reg  <= d2;
            dr3_reg <= dr2; di3_reg <= di2;
            cmd3_reg <= cmd2_reg; direct3_reg <= direct2;
        end
    end

    // quotient pipeline, one bit per stage for both parts; root rides alongside
    logic [RW-1:0] rr_reg [0:NB];
    logic [RW-1:0] ri_reg [0:NB];
    logic [NW-1:0] qr_reg [0:NB];
    logic [NW-1:0] qi_reg [0:NB];
    logic [DW-1:0] dd_reg [0:NB];
    logic          sgr_reg [0:NB];
    logic          sgi_reg [0:NB];
    logic signed [XW-1:0] xr_reg [0:NB];
    logic signed [XW-1:0] xi_reg [0:NB];
    logic [CMD_W-1:0] cm_reg [0:NB];
    logic          dir_reg [0:NB];
    logic          vq_reg [0:NB];
    logic [SRW-1:0] sr_reg [0:NB];
    logic [SB-1:0]  sq_reg [0:NB];
    logic [2*SB-1:0] sv_reg [0:NB];

    always_comb
    begin
        rr_reg[0] = '0; ri_reg[0] = '0;
        qr_reg[0] = mr3_reg; qi_reg[0] = mi3_reg;
        dd_reg[0] = d3_reg; sgr_reg[0] = sr3_reg; sgi_reg[0] = si3_reg;
        xr_reg[0] = dr3_reg; xi_reg[0] = di3_reg;
        cm_reg[0] = cmd3_reg; dir_reg[0] = direct3_reg; vq_reg[0] = v3_reg;
        sr_reg[0] = '0; sq_reg[0] = '0; sv_reg[0] = (2*SB)'(d3_reg);
    end

    genvar g;
    generate
        for (g = 0; g < NB; g++)
        begin : g_q
            logic [RW-1:0] nrr, nri;
            logic br, bi;
            cau_divstage #(.RW(RW)) u_re (
                .rem_in (rr_reg[g]),
                .bit_in (qr_reg[g][NW-1]),
                .div_in (RW'(dd_reg[g])),
                .rem_out(nrr),
                .q_out  (br)
            );
            cau_divstage #(.RW(RW)) u_im (
                .rem_in (ri_reg[g]),
                .bit_in (qi_reg[g][NW-1]),
                .div_in (RW'(dd_reg[g])),
                .rem_out(nri),
                .q_out  (bi)
            );
            // root step: two radicand bits in, trial 4q+1
            logic [SRW-1:0] sr_n;
            logic [SB-1:0]  sq_n;
            logic [SRW:0]   s_sh, s_tr;
            always_comb
            begin
                s_sh = {sr_reg[g][SRW-2:0], sv_reg[g][2*SB-1:2*SB-2]};
                s_tr = s_sh - {(SRW+1)'({sq_reg[g], 2'b01})};
                sr_n = sr_reg[g];
                sq_n = sq_reg[g];
                if (g < SB)
                begin
                    if (!s_tr[SRW])
                    begin
                        sr_n = s_tr[SRW-1:0];
                        sq_n = {sq_reg[g][SB-2:0], 1'b1};
                    end
                    else
                    begin
                        sr_n = s_sh[SRW-1:0];
                        sq_n = {sq_reg[g][SB-2:0], 1'b0};
                    end
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vq_reg[g+1] <= 1'b0;
                else if (en)
                    vq_reg[g+1] <= vq_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rr_reg[g+1] <= nrr;
                    ri_reg[g+1] <= nri;
                    qr_reg[g+1] <= {qr_reg[g][NW-2:0], br};
                    qi_reg[g+1] <= {qi_reg[g][NW-2:0], bi};
                    dd_reg[g+1] <= dd_reg[g];
                    sgr_reg[g+1] <= sgr_reg[g]; sgi_reg[g+1] <= sgi_reg[g];
                    xr_reg[g+1] <= xr_reg[g]; xi_reg[g+1] <= xi_reg[g];
                    cm_reg[g+1] <= cm_reg[g]; dir_reg[g+1] <= dir_reg[g];
                    sr_reg[g+1] <= sr_n;
                    sq_reg[g+1] <= sq_n;
                    sv_reg[g+1] <= (g < SB) ? {sv_reg[g][2*SB-3:0], 2'b00} : sv_reg[g];
                end
            end
        end
    endgenerate

    // final stage: sign fix-up, result select, saturation
    localparam logic signed [XW-1:0] HI = XW'((65'sd1 <<< (W-1)) - 65'sd1);
    localparam logic signed [XW-1:0] LO = -XW'(65'sd1 <<< (W-1));
    logic signed [XW-1:0] fr, fi;
    logic [STAT_W-1:0] st;
    logic ov;
    logic [W-1:0] or_v, oi_v;
    always_comb
    begin
        fr = sgr_reg[NB] ? -XW'({1'b0, qr_reg[NB]}) - XW'(rr_reg[NB] != '0)
                         : XW'({1'b0, qr_reg[NB]});
        fi = sgi_reg[NB] ? -XW'({1'b0, qi_reg[NB]}) - XW'(ri_reg[NB] != '0)
                         : XW'({1'b0, qi_reg[NB]});
        st = ST_OK;
        if (dir_reg[NB])
        begin
            fr = xr_reg[NB]; fi = xi_reg[NB];
        end
        else if (cm_reg[NB] == OP_MAG)
        begin
            fr = XW'(sq_reg[NB]); fi = '0;
        end
        else if (dd_reg[NB] == '0)
        begin
            fr = '0; fi = '0; st = ST_DBZ;
        end
        ov = 1'b0;
        if (fr > HI) begin or_v = HI[W-1:0]; ov = 1'b1; end
        else if (fr < LO) begin or_v = LO[W-1:0]; ov = 1'b1; end
        else or_v = fr[W-1:0];
        if (fi > HI) begin oi_v = HI[W-1:0]; ov = 1'b1; end
        else if (fi < LO) begin oi_v = LO[W-1:0]; ov = 1'b1; end
        else oi_v = fi[W-1:0];
        if (st == ST_OK && ov)
            st = ST_OVF;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= vq_reg[NB];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_axis_tdata <= {oi_v, or_v};
            m_axis_tuser <= st;
        end
    end
endmodule

// ===== tb/cau_checker.sv =====
// checker: watches both streams, predicts each result and compares it
`timescale 1ns / 1ps
module cau_checker import cau_pkg::*; #(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int FRAC_BITS  = FRAC_W_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [4*DATA_WIDTH-1:0] s_axis_tdata,
    input  logic [CMD_W-1:0]        s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [2*DATA_WIDTH-1:0] m_axis_tdata,
    input  logic [STAT_W-1:0]       m_axis_tuser,
    output int                      mismatches,
    output int                      outstanding
);
    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] re;
        logic [DATA_WIDTH-1:0] im;
        logic [STAT_W-1:0]     status;
    } cplx_result_t;

    cplx_result_t result_q[$];

    // division rounded toward minus infinity, divisor positive
    function automatic wide_t div_floor(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n % d != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // integer square root, floor
    function automatic wide_t root_floor(wide_t v);
        wide_t r;
        wide_t t;
        r = 0;
        for (int b = DATA_WIDTH + 1; b >= 0; b--)
        begin
            t = r | (wide_t'(1) <<< b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // clamp to the signed word range, noting overflow
    function automatic logic [DATA_WIDTH-1:0] clamp_word(wide_t x, inout bit ovf);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -(wide_t'(1) <<< (DATA_WIDTH - 1));
        if (x > hi)
        begin
            ovf = 1'b1;
            x = hi;
        end
        else if (x < lo)
        begin
            ovf = 1'b1;
            x = lo;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    function automatic wide_t sext(logic [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] s;
        s = v;
        return wide_t'(s);
    endfunction

    // expected result of one operation
    function automatic cplx_result_t complex_op(logic [CMD_W-1:0] cmd,
                                                logic [4*DATA_WIDTH-1:0] ops);
        cplx_result_t res;
        wide_t ar, ai, br, bi, rr, ri, den, one_f;
        bit ovf;
        bit dbz;
        ar = sext(ops[0*DATA_WIDTH +: DATA_WIDTH]);
        ai = sext(ops[1*DATA_WIDTH +: DATA_WIDTH]);
        br = sext(ops[2*DATA_WIDTH +: DATA_WIDTH]);
        bi = sext(ops[3*DATA_WIDTH +: DATA_WIDTH]);
        one_f = wide_t'(1) <<< FRAC_BITS;
        rr = 0;
        ri = 0;
        ovf = 1'b0;
        dbz = 1'b0;
        case (cmd)
            OP_ADD:
            begin
                rr = ar + br;
                ri = ai + bi;
            end
            OP_SUB:
            begin
                rr = ar - br;
                ri = ai - bi;
            end
            OP_MUL:
            begin
                rr = (ar * br - ai * bi) >>> FRAC_BITS;
                ri = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    dbz = 1'b1;
                else
                begin
                    rr = div_floor((ar * br + ai * bi) * one_f, den);
                    ri = div_floor((ai * br - ar * bi) * one_f, den);
                end
            end
            OP_CNJ:
            begin
                rr = ar;
                ri = -ai;
            end
            OP_MAG:
                rr = root_floor(ar * ar + ai * ai);
            OP_INV:
            begin
                den = ar * ar + ai * ai;
                if (den == 0)
                    dbz = 1'b1;
                else
                begin
                    rr = div_floor(ar * one_f * one_f, den);
                    ri = div_floor(-ai * one_f * one_f, den);
                end
            end
            default:
            begin
                rr = 0;
                ri = 0;
            end
        endcase
        res.re = clamp_word(rr, ovf);
        res.im = clamp_word(ri, ovf);
        res.status = dbz ? ST_DBZ : (ovf ? ST_OVF : ST_OK);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                   logic [DATA_WIDTH-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // predict on each input transfer, compare on each output transfer
    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(complex_op(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata[DATA_WIDTH-1:0], '0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_axis_tdata[DATA_WIDTH-1:0] !== want.re)
                        report_mismatch("res_re", m_axis_tdata[DATA_WIDTH-1:0], want.re);
                    if (m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] !== want.im)
                        report_mismatch("res_im", m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH],
                                        want.im);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", DATA_WIDTH'(m_axis_tuser),
                                        DATA_WIDTH'(want.status));
                end
            end
            outstanding = result_q.size();
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// testbench top: clock, reset, operand stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_top;
    import cau_pkg::*;

    localparam int DW          = DATA_W_DEF;
    localparam int FW          = FRAC_W_DEF;
    localparam int RAND_ITEMS  = 1550;
    localparam int DRAIN_WAIT  = 1100;
    localparam int STALL_LIMIT = 5000;

    localparam logic [DW-1:0] W_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] W_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] W_ONE  = DW'(1) << FW;
    localparam logic [DW-1:0] W_MONE = -(DW'(1) << FW);

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [4*DW-1:0]   s_axis_tdata;
    logic [CMD_W-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [2*DW-1:0]   m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;
    int                mismatches;
    int                outstanding;
    int                idle_cycles;

    complex_arith_unit u_dut (.*);

    cau_checker u_checker (.*);

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver stalls in runs of random length, sometimes not at all
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            case ($urandom_range(0, 3))
                0:       m_axis_tready <= ($urandom_range(0, 9) != 0);
                1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= m_axis_tready ? ($urandom_range(0, 15) != 0)
                                                        : ($urandom_range(0, 2) == 0);
            endcase
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // operand value biased toward extremes and small magnitudes
    function automatic logic [DW-1:0] pick_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 6))
                    0:       v = W_MAX;
                    1:       v = W_MIN;
                    2:       v = '0;
                    3:       v = '1;
                    4:       v = W_ONE;
                    5:       v = W_MONE;
                    default: v = DW'(1);
                endcase
            1, 2:    v = DW'($urandom_range(0, 255)) - DW'(128);
            3, 4, 5: v = DW'($urandom_range(0, 1 << 22)) - DW'(1 << 21);
            default: v = DW'($urandom);
        endcase
        return v;
    endfunction

    // one transfer: present at the edge, hold until the block takes it
    task automatic send_op(logic [CMD_W-1:0] cmd, logic [DW-1:0] ar, logic [DW-1:0] ai,
                           logic [DW-1:0] br, logic [DW-1:0] bi);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {bi, br, ai, ar};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [DW-1:0]    bi;
        int               burst;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, every operation, divide by zero and overflow
        send_op(OP_ADD, W_MAX, W_MIN, W_MAX, W_MIN);
        send_op(OP_ADD, W_ONE, W_MONE, W_MONE, W_ONE);
        send_op(OP_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
        send_op(OP_SUB, W_ONE, '0, DW'(3), '0);
        send_op(OP_MUL, W_MAX, W_MAX, W_MAX, W_MIN);
        send_op(OP_MUL, W_MONE, W_ONE, W_ONE, W_ONE);
        send_op(OP_MUL, '1, '1, DW'(1), '0);
        send_op(OP_DIV, W_ONE, W_ONE, '0, '0);
        send_op(OP_DIV, W_MAX, W_MIN, DW'(1), '0);
        send_op(OP_DIV, '1, DW'(5), W_ONE, W_MONE);
        send_op(OP_DIV, W_MIN, '0, W_MONE, '0);
        send_op(OP_DIV, W_ONE, '0, W_MIN, W_MIN);
        send_op(OP_CNJ, W_MAX, W_MIN, '0, '0);
        send_op(OP_CNJ, W_MIN, W_MAX, W_MAX, W_MAX);
        send_op(OP_MAG, W_MIN, W_MIN, '0, '0);
        send_op(OP_MAG, '0, '0, '0, '0);
        send_op(OP_MAG, DW'(3) << FW, DW'(4) << FW, '0, '0);
        send_op(OP_MAG, '1, DW'(1), '0, '0);
        send_op(OP_INV, '0, '0, W_ONE, '0);
        send_op(OP_INV, W_ONE, '0, '0, '0);
        send_op(OP_INV, DW'(1), '0, '0, '0);
        send_op(OP_INV, W_MIN, W_MAX, '0, '0);
        send_op(OP_INV, W_MONE, W_MONE, '0, '0);

        // random bursts with gaps of random length
        for (int n = 0; n < RAND_ITEMS; )
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            for (int k = 0; k < burst && n < RAND_ITEMS; k++, n++)
            begin
                cmd = CMD_W'($urandom_range(OP_ADD, OP_INV));
                bi = ($urandom_range(0, 4) == 0) ? '0 : pick_operand();
                send_op(cmd, pick_operand(), pick_operand(), pick_operand(), bi);
            end
            pause_sender($urandom_range(0, 6));
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for anything still in the pipe
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/cau_pkg.sv
hdl/cau_divstage.sv
hdl/complex_arith_unit.sv
tb/cau_checker.sv
tb/tb_top.sv
